### hw/rtl/dmcr_pkg.sv
// Shared constants for the direct-mapped cache refill core.
// Holds geometry, command, status and register codes; depends on nothing.
package dmcr_pkg;

    localparam int INDEX_BITS  = 4;
    localparam int OFFSET_BITS = 2;

    localparam int ADDR_W      = 32;
    localparam int WORD_W      = 32;
    localparam int TAG_SHIFT   = 2 + INDEX_BITS + OFFSET_BITS;
    localparam int TAG_W       = ADDR_W - TAG_SHIFT;
    localparam int SLOT_BITS   = INDEX_BITS + OFFSET_BITS;
    localparam int BLOCK_COUNT = 1 << INDEX_BITS;
    localparam int NUM_WORDS   = 1 << SLOT_BITS;
    localparam int BLK_WORDS   = 1 << OFFSET_BITS;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] ST_HIT       = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_NO_ACCESS = 2'd2;

    localparam logic [1:0] REG_WRITE_POLICY = 2'd0;
    localparam logic [1:0] REG_MISS_PENALTY = 2'd1;
    localparam logic [1:0] REG_SUB_PENALTY  = 2'd2;

    localparam logic [7:0] MISS_PENALTY_RST = 8'd8;
    localparam logic [7:0] SUB_PENALTY_RST  = 8'd2;

endpackage

### hw/rtl/direct_mapped_cache_refill_core.sv
// Top level of the direct-mapped cache refill core.
// Depends on dmcr_pkg for geometry, command, status and register codes.
//
// The block takes one word per cycle on the s_ channel (valid/ready) while
// s_ready is high: a read, a write or one memory tick, with the memory grant,
// refill word and write buffer state that belong to it. Each word gives
// exactly one result word on the m_ channel: access status, read data, an
// optional write-buffer entry, the refill state after the word and a memory
// release flag. A word is held in the input register, is looked up and
// applied to the cache state by a single pass of logic, and lands in the
// result register. One word is accepted and one result delivered every
// cycle while m_ready stays high. The data array is read as the word is
// accepted, with a bypass for the write made in the same cycle.
// While m_ready is low the result register holds, the input register still
// takes one more word, and then s_ready drops until the result is taken.
// Reset empties both registers, clears all word valid bits, dirty bits and
// the refill state, and loads the register defaults: write-back, miss
// penalty 8, subsequent penalty 2; pready is always high. The user must
// write registers over the APB port only while the block is idle; the
// block itself does not enforce this.
module direct_mapped_cache_refill_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dmcr_pkg::PADDR_W-1:0]     paddr,
    input  logic [dmcr_pkg::PDATA_W-1:0]     pwdata,
    output logic [dmcr_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic [dmcr_pkg::ADDR_W-1:0]      s_address,
    input  logic [dmcr_pkg::WORD_W-1:0]      s_write_data,
    input  logic                             s_mem_granted,
    input  logic [dmcr_pkg::WORD_W-1:0]      s_mem_word,
    input  logic                             s_wbuf_full,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [dmcr_pkg::WORD_W-1:0]      m_read_data,
    output logic                             m_wb_valid,
    output logic [dmcr_pkg::ADDR_W-1:0]      m_wb_address,
    output logic [dmcr_pkg::WORD_W-1:0]      m_wb_data,
    output logic                             m_refill_pending,
    output logic [dmcr_pkg::ADDR_W-1:0]      m_refill_address,
    output logic                             m_mem_release
);

    localparam int IB = dmcr_pkg::INDEX_BITS;
    localparam int OB = dmcr_pkg::OFFSET_BITS;
    localparam int SB = dmcr_pkg::SLOT_BITS;
    localparam int TS = dmcr_pkg::TAG_SHIFT;
    localparam int TW = dmcr_pkg::TAG_W;
    localparam int AW = dmcr_pkg::ADDR_W;
    localparam int WW = dmcr_pkg::WORD_W;

    // Configuration registers.
    logic       write_policy_reg;
    logic [7:0] miss_penalty_reg;
    logic [7:0] sub_penalty_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_policy_reg <= 1'b0;
            miss_penalty_reg <= dmcr_pkg::MISS_PENALTY_RST;
            sub_penalty_reg  <= dmcr_pkg::SUB_PENALTY_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                dmcr_pkg::REG_WRITE_POLICY: write_policy_reg <= pwdata[0];
                dmcr_pkg::REG_MISS_PENALTY: miss_penalty_reg <= pwdata[7:0];
                dmcr_pkg::REG_SUB_PENALTY:  sub_penalty_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            dmcr_pkg::REG_WRITE_POLICY: prdata[0]   = write_policy_reg;
            dmcr_pkg::REG_MISS_PENALTY: prdata[7:0] = miss_penalty_reg;
            dmcr_pkg::REG_SUB_PENALTY:  prdata[7:0] = sub_penalty_reg;
            default: prdata = '0;
        endcase
    end

    // Input register.
    logic          in_valid_reg;
    logic [1:0]    in_cmd_reg;
    logic [AW-1:0] in_addr_reg;
    logic [WW-1:0] in_wdata_reg;
    logic          in_granted_reg;
    logic [WW-1:0] in_mword_reg;
    logic          in_full_reg;

    logic out_valid_reg;
    logic proc_fire;
    logic s_fire;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg     <= s_cmd;
            in_addr_reg    <= s_address;
            in_wdata_reg   <= s_write_data;
            in_granted_reg <= s_mem_granted;
            in_mword_reg   <= s_mem_word;
            in_full_reg    <= s_wbuf_full;
        end
    end

    // Cache state.
    logic [TW-1:0]                    tag_store [dmcr_pkg::BLOCK_COUNT];
    logic [dmcr_pkg::NUM_WORDS-1:0]   word_valid_reg, word_valid_next;
    logic [dmcr_pkg::BLOCK_COUNT-1:0] block_dirty_reg, block_dirty_next;
    logic                             fetch_busy_reg, fetch_busy_next;
    logic [7:0]                       wait_count_reg, wait_count_next;
    logic [OB-1:0]                    next_word_reg, next_word_next;
    logic [AW-1:0]                    fetch_addr_reg, fetch_addr_next;

    // Data array with registered read and same-cycle write bypass.
    logic [WW-1:0] word_store [dmcr_pkg::NUM_WORDS];
    logic [WW-1:0] rd_data_reg;
    logic          byp_hit_reg;
    logic [WW-1:0] byp_data_reg;
    logic          mem_we;
    logic [SB-1:0] mem_wa;
    logic [WW-1:0] mem_wd;
    logic [SB-1:0] s_slot;
    logic [WW-1:0] stored_word;

    assign s_slot      = s_address[TS-1:2];
    assign stored_word = byp_hit_reg ? byp_data_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (proc_fire && mem_we) begin
            word_store[mem_wa] <= mem_wd;
        end
        if (s_fire) begin
            rd_data_reg  <= word_store[s_slot];
            byp_hit_reg  <= proc_fire && mem_we && (mem_wa == s_slot);
            byp_data_reg <= mem_wd;
        end
    end

    // Single pass over the word in the input register.
    logic [IB-1:0] blk;
    logic [SB-1:0] slot;
    logic [TW-1:0] tag;
    logic          hit;
    logic          start;
    logic [IB-1:0] f_blk;
    logic [OB-1:0] f_word;
    logic [SB-1:0] f_slot;
    logic [7:0]    limit;
    logic [7:0]    wait_inc;
    logic          tag_we;
    logic [IB-1:0] tag_wa;
    logic [TW-1:0] tag_wd;

    logic [1:0]    status;
    logic [WW-1:0] read_data;
    logic          wb_valid;
    logic [AW-1:0] wb_address;
    logic [WW-1:0] wb_data;
    logic          release_w;

    assign blk    = in_addr_reg[TS-1:2+OB];
    assign slot   = in_addr_reg[TS-1:2];
    assign tag    = in_addr_reg[AW-1:TS];
    assign hit    = word_valid_reg[slot] && (tag_store[blk] == tag);
    assign f_blk  = fetch_addr_reg[TS-1:2+OB];
    assign f_word = next_word_reg;
    assign f_slot = {f_blk, f_word};

    always_comb begin
        word_valid_next  = word_valid_reg;
        block_dirty_next = block_dirty_reg;
        fetch_busy_next  = fetch_busy_reg;
        wait_count_next  = wait_count_reg;
        next_word_next   = next_word_reg;
        fetch_addr_next  = fetch_addr_reg;
        mem_we     = 1'b0;
        mem_wa     = slot;
        mem_wd     = in_wdata_reg;
        tag_we     = 1'b0;
        tag_wa     = f_blk;
        tag_wd     = fetch_addr_reg[AW-1:TS];
        status     = dmcr_pkg::ST_NO_ACCESS;
        read_data  = '0;
        wb_valid   = 1'b0;
        wb_address = '0;
        wb_data    = '0;
        release_w  = 1'b0;
        start      = 1'b0;
        limit      = (f_word == '0) ? miss_penalty_reg : sub_penalty_reg;
        wait_inc   = wait_count_reg + 8'd1;

        case (in_cmd_reg)
            dmcr_pkg::CMD_READ: begin
                if (hit) begin
                    status    = dmcr_pkg::ST_HIT;
                    read_data = stored_word;
                end else begin
                    status = dmcr_pkg::ST_MISS;
                    start  = !fetch_busy_reg;
                    if (start && block_dirty_reg[blk] && !write_policy_reg) begin
                        if (in_full_reg) begin
                            start = 1'b0;
                        end else begin
                            wb_valid   = 1'b1;
                            wb_address = {tag_store[blk], in_addr_reg[TS-1:2], 2'b00};
                            wb_data    = stored_word;
                        end
                    end
                    if (start) begin
                        fetch_busy_next = 1'b1;
                        fetch_addr_next = {in_addr_reg[AW-1:TS], {TS{1'b0}}};
                        wait_count_next = '0;
                        next_word_next  = '0;
                    end
                end
            end
            dmcr_pkg::CMD_WRITE: begin
                if (hit) begin
                    status                = dmcr_pkg::ST_HIT;
                    mem_we                = 1'b1;
                    block_dirty_next[blk] = 1'b1;
                    if (write_policy_reg) begin
                        if (in_full_reg) begin
                            status = dmcr_pkg::ST_MISS;
                        end else begin
                            wb_valid   = 1'b1;
                            wb_address = {in_addr_reg[AW-1:2], 2'b00};
                            wb_data    = in_wdata_reg;
                        end
                    end
                end else begin
                    status = dmcr_pkg::ST_MISS;
                end
            end
            dmcr_pkg::CMD_TICK: begin
                if (fetch_busy_reg && in_granted_reg) begin
                    if (wait_inc != limit) begin
                        wait_count_next = wait_inc;
                    end else begin
                        wait_count_next = '0;
                        mem_we = 1'b1;
                        mem_wa = f_slot;
                        mem_wd = in_mword_reg;
                        tag_we = 1'b1;
                        if (f_word == '0) begin
                            for (int i = 0; i < dmcr_pkg::BLK_WORDS; i++) begin
                                word_valid_next[{f_blk, OB'(i)}] = 1'b0;
                            end
                            block_dirty_next[f_blk] = 1'b0;
                        end
                        word_valid_next[f_slot] = 1'b1;
                        if (f_word != {OB{1'b1}}) begin
                            next_word_next = f_word + OB'(1);
                            fetch_addr_next[2+OB-1:2] = f_word + OB'(1);
                        end else begin
                            next_word_next  = '0;
                            fetch_busy_next = 1'b0;
                            release_w       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_valid_reg  <= '0;
            block_dirty_reg <= '0;
            fetch_busy_reg  <= 1'b0;
            wait_count_reg  <= '0;
            next_word_reg   <= '0;
            fetch_addr_reg  <= '0;
        end else if (proc_fire) begin
            word_valid_reg  <= word_valid_next;
            block_dirty_reg <= block_dirty_next;
            fetch_busy_reg  <= fetch_busy_next;
            wait_count_reg  <= wait_count_next;
            next_word_reg   <= next_word_next;
            fetch_addr_reg  <= fetch_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && tag_we) begin
            tag_store[tag_wa] <= tag_wd;
        end
    end

    // Result register.
    logic [1:0]    status_reg;
    logic [WW-1:0] read_data_reg;
    logic          wb_valid_reg;
    logic [AW-1:0] wb_address_reg;
    logic [WW-1:0] wb_data_reg;
    logic          refill_pending_reg;
    logic [AW-1:0] refill_address_reg;
    logic          mem_release_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            status_reg         <= status;
            read_data_reg      <= read_data;
            wb_valid_reg       <= wb_valid;
            wb_address_reg     <= wb_address;
            wb_data_reg        <= wb_data;
            refill_pending_reg <= fetch_busy_next;
            refill_address_reg <= fetch_busy_next ? fetch_addr_next : '0;
            mem_release_reg    <= release_w;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_read_data      = read_data_reg;
    assign m_wb_valid       = wb_valid_reg;
    assign m_wb_address     = wb_address_reg;
    assign m_wb_data        = wb_data_reg;
    assign m_refill_pending = refill_pending_reg;
    assign m_refill_address = refill_address_reg;
    assign m_mem_release    = mem_release_reg;

endmodule

### verif/direct_mapped_cache_refill_core_tb.sv
// Self-checking testbench for direct_mapped_cache_refill_core: directed and random
// reads, writes and memory ticks are predicted by a cycle-free cache model and compared.
// Depends on dmcr_pkg and the core RTL only.
module direct_mapped_cache_refill_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = dmcr_pkg::ADDR_W;
    localparam int WORD_W      = dmcr_pkg::WORD_W;
    localparam int PADDR_W     = dmcr_pkg::PADDR_W;
    localparam int PDATA_W     = dmcr_pkg::PDATA_W;
    localparam int TAG_W       = dmcr_pkg::TAG_W;
    localparam int TAG_SHIFT   = dmcr_pkg::TAG_SHIFT;
    localparam int INDEX_BITS  = dmcr_pkg::INDEX_BITS;
    localparam int OFFSET_BITS = dmcr_pkg::OFFSET_BITS;
    localparam int SLOT_BITS   = dmcr_pkg::SLOT_BITS;
    localparam int BLK_WORDS   = dmcr_pkg::BLK_WORDS;
    localparam int BLOCK_COUNT = dmcr_pkg::BLOCK_COUNT;
    localparam int NUM_WORDS   = dmcr_pkg::NUM_WORDS;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 3000;
    localparam logic [ADDR_W-1:0] ADDR_A = 32'hFFFF_FF08;
    localparam logic [ADDR_W-1:0] ADDR_B = 32'h1234_5678;
    localparam logic [ADDR_W-1:0] ADDR_C = 32'h0000_000B;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] write_data;
        logic              mem_granted;
        logic [WORD_W-1:0] mem_word;
        logic              wbuf_full;
    } cache_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] read_data;
        logic              wb_valid;
        logic [ADDR_W-1:0] wb_address;
        logic [WORD_W-1:0] wb_data;
        logic              refill_pending;
        logic [ADDR_W-1:0] refill_address;
        logic              mem_release;
    } cache_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_cmd = dmcr_pkg::CMD_READ;
    logic [ADDR_W-1:0] s_address = '0;
    logic [WORD_W-1:0] s_write_data = '0;
    logic              s_mem_granted = 1'b0;
    logic [WORD_W-1:0] s_mem_word = '0;
    logic              s_wbuf_full = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [WORD_W-1:0] m_read_data;
    logic              m_wb_valid;
    logic [ADDR_W-1:0] m_wb_address;
    logic [WORD_W-1:0] m_wb_data;
    logic              m_refill_pending;
    logic [ADDR_W-1:0] m_refill_address;
    logic              m_mem_release;

    direct_mapped_cache_refill_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_address        (s_address),
        .s_write_data     (s_write_data),
        .s_mem_granted    (s_mem_granted),
        .s_mem_word       (s_mem_word),
        .s_wbuf_full      (s_wbuf_full),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_read_data      (m_read_data),
        .m_wb_valid       (m_wb_valid),
        .m_wb_address     (m_wb_address),
        .m_wb_data        (m_wb_data),
        .m_refill_pending (m_refill_pending),
        .m_refill_address (m_refill_address),
        .m_mem_release    (m_mem_release)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Cache state as the core should hold it after every accepted word.
    logic              wr_through;
    logic [7:0]        first_wait;
    logic [7:0]        next_wait;
    logic [TAG_W-1:0]  tag_mem [BLOCK_COUNT];
    logic [WORD_W-1:0] word_mem [NUM_WORDS];
    logic              word_ok [NUM_WORDS];
    logic              dirty [BLOCK_COUNT];
    logic              fetching;
    logic [7:0]        wait_cnt;
    logic [OFFSET_BITS-1:0] fetch_word;
    logic [ADDR_W-1:0] fetch_addr;

    cache_req_t    pending_accesses[$];
    cache_result_t expected_results[$];
    cache_req_t    on_bus;
    cache_result_t predicted;
    cache_result_t due;

    int   mismatches = 0;
    int   results_seen = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    logic held_off = 1'b0;
    logic [9:0] cycle_no = '0;
    wire  calm = cycle_no[9] & cycle_no[8];

    function automatic logic [INDEX_BITS-1:0] index_of(logic [ADDR_W-1:0] a);
        return a[2+OFFSET_BITS +: INDEX_BITS];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [WORD_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic cache_predict(input cache_req_t a, output cache_result_t r);
        logic [INDEX_BITS-1:0] b;
        logic [INDEX_BITS-1:0] fb;
        logic [SLOT_BITS-1:0]  slot;
        logic [SLOT_BITS-1:0]  fslot;
        logic [7:0]            lim;
        logic                  hit;
        logic                  start;
        int                    i;
        r = '0;
        r.status = dmcr_pkg::ST_NO_ACCESS;
        b = index_of(a.address);
        slot = {b, a.address[2 +: OFFSET_BITS]};
        hit = word_ok[slot] && tag_mem[b] == a.address[ADDR_W-1:TAG_SHIFT];
        case (a.cmd)
            dmcr_pkg::CMD_READ: begin
                if (hit) begin
                    r.status = dmcr_pkg::ST_HIT;
                    r.read_data = word_mem[slot];
                end else begin
                    r.status = dmcr_pkg::ST_MISS;
                    start = !fetching;
                    if (start && dirty[b] && !wr_through) begin
                        if (a.wbuf_full) begin
                            start = 1'b0;
                        end else begin
                            r.wb_valid = 1'b1;
                            r.wb_address = {tag_mem[b], a.address[TAG_SHIFT-1:2], 2'b00};
                            r.wb_data = word_mem[slot];
                        end
                    end
                    if (start) begin
                        fetching = 1'b1;
                        fetch_addr = {a.address[ADDR_W-1:TAG_SHIFT], TAG_SHIFT'(0)};
                        wait_cnt = '0;
                        fetch_word = '0;
                    end
                end
            end
            dmcr_pkg::CMD_WRITE: begin
                if (hit) begin
                    r.status = dmcr_pkg::ST_HIT;
                    word_mem[slot] = a.write_data;
                    dirty[b] = 1'b1;
                    if (wr_through) begin
                        if (a.wbuf_full) begin
                            r.status = dmcr_pkg::ST_MISS;
                        end else begin
                            r.wb_valid = 1'b1;
                            r.wb_address = {a.address[ADDR_W-1:2], 2'b00};
                            r.wb_data = a.write_data;
                        end
                    end
                end else begin
                    r.status = dmcr_pkg::ST_MISS;
                end
            end
            dmcr_pkg::CMD_TICK: begin
                if (fetching && a.mem_granted) begin
                    fb = index_of(fetch_addr);
                    lim = (fetch_word == 0) ? first_wait : next_wait;
                    wait_cnt = wait_cnt + 8'd1;
                    if (wait_cnt == lim) begin
                        wait_cnt = '0;
                        fslot = {fb, fetch_word};
                        word_mem[fslot] = a.mem_word;
                        tag_mem[fb] = fetch_addr[ADDR_W-1:TAG_SHIFT];
                        if (fetch_word == 0) begin
                            for (i = 1; i < BLK_WORDS; i++) begin
                                word_ok[{fb, OFFSET_BITS'(i)}] = 1'b0;
                            end
                            dirty[fb] = 1'b0;
                        end
                        word_ok[fslot] = 1'b1;
                        if (fetch_word == OFFSET_BITS'(BLK_WORDS - 1)) begin
                            fetch_word = '0;
                            fetching = 1'b0;
                            r.mem_release = 1'b1;
                        end else begin
                            fetch_word = fetch_word + 1'b1;
                            fetch_addr[2 +: OFFSET_BITS] = fetch_word;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.refill_pending = fetching;
        r.refill_address = fetching ? fetch_addr : '0;
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // Driver: offers the next pending word, holds it until accepted, and
    // predicts the result of every word at the edge that accepts it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                cache_predict(on_bus, predicted);
                expected_results.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    on_bus = pending_accesses.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= on_bus.cmd;
                    s_address <= on_bus.address;
                    s_write_data <= on_bus.write_data;
                    s_mem_granted <= on_bus.mem_granted;
                    s_mem_word <= on_bus.mem_word;
                    s_wbuf_full <= on_bus.wbuf_full;
                    gap_left <= (calm || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure, with one long hold-off while words keep coming.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (!held_off && results_seen >= 250) begin
            held_off <= 1'b1;
            stall_left <= 90;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, status %0d", $time, m_status);
            end else begin
                due = expected_results.pop_front();
                check_field("status", 32'(due.status), 32'(m_status));
                check_field("read_data", due.read_data, m_read_data);
                check_field("wb_valid", 32'(due.wb_valid), 32'(m_wb_valid));
                check_field("wb_address", due.wb_address, m_wb_address);
                check_field("wb_data", due.wb_data, m_wb_data);
                check_field("refill_pending", 32'(due.refill_pending), 32'(m_refill_pending));
                check_field("refill_address", due.refill_address, m_refill_address);
                check_field("mem_release", 32'(due.mem_release), 32'(m_mem_release));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1'b1;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic void add(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                logic [WORD_W-1:0] wdata, logic granted,
                                logic [WORD_W-1:0] mword, logic full);
        cache_req_t t;
        t.cmd = cmd;
        t.address = addr;
        t.write_data = wdata;
        t.mem_granted = granted;
        t.mem_word = mword;
        t.wbuf_full = full;
        pending_accesses.push_back(t);
    endfunction

    function automatic void queue_ticks(int granted_needed, logic with_idle);
        int got;
        logic granted;
        got = 0;
        while (got < granted_needed) begin
            granted = !with_idle || $urandom_range(0, 7) != 0;
            if (granted) begin
                got++;
            end
            add(dmcr_pkg::CMD_TICK, $urandom, $urandom, granted, extreme_word(),
                $urandom_range(0, 1));
        end
    endfunction

    function automatic void queue_random(int count);
        logic [TAG_W-1:0]       pool [3];
        logic [INDEX_BITS-1:0]  idx;
        logic [OFFSET_BITS-1:0] wsel;
        logic [1:0]             cmd;
        logic [ADDR_W-1:0]      addr;
        int                     r;
        foreach (pool[k]) begin
            pool[k] = TAG_W'($urandom);
        end
        repeat (count) begin
            r = $urandom_range(0, 99);
            cmd = r < 42 ? dmcr_pkg::CMD_TICK : r < 70 ? dmcr_pkg::CMD_READ :
                  r < 95 ? dmcr_pkg::CMD_WRITE : CMD_UNUSED;
            idx = ($urandom_range(0, 3) == 0) ? INDEX_BITS'($urandom) : '0;
            wsel = OFFSET_BITS'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                addr = $urandom;
            end else begin
                addr = {pool[$urandom_range(0, 2)], idx, wsel, 2'($urandom)};
            end
            add(cmd, addr, extreme_word(), $urandom_range(0, 7) != 0, $urandom,
                $urandom_range(0, 4) == 0);
        end
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic wp, logic [7:0] first, logic [7:0] later);
        reg_write(dmcr_pkg::REG_WRITE_POLICY, PDATA_W'(wp));
        reg_write(dmcr_pkg::REG_MISS_PENALTY, PDATA_W'(first));
        reg_write(dmcr_pkg::REG_SUB_PENALTY, PDATA_W'(later));
        wr_through = wp;
        first_wait = first;
        next_wait = later;
    endtask

    // Waits for every result, then ticks any open refill to its end so the
    // next register writes find the core idle.
    task automatic settle();
        do begin
            while (pending_accesses.size() != 0 || s_valid || expected_results.size() != 0) begin
                @(posedge aclk);
            end
            repeat (4) @(posedge aclk);
            if (fetching) begin
                queue_ticks(64, 1'b0);
            end
        end while (fetching || pending_accesses.size() != 0);
    endtask

    task automatic long_refill_phase(logic wp, logic [7:0] first, logic [7:0] later);
        int need;
        set_config(wp, first, later);
        need = (first == 0 ? 256 : int'(first)) + (BLK_WORDS - 1) * (later == 0 ? 256 : int'(later));
        add(dmcr_pkg::CMD_READ, {TAG_W'($urandom), TAG_SHIFT'(0)}, $urandom, 1'b1, $urandom,
            1'b0);
        queue_ticks(need, 1'b1);
        settle();
    endtask

    initial begin
        wr_through = 1'b0;
        first_wait = dmcr_pkg::MISS_PENALTY_RST;
        next_wait = dmcr_pkg::SUB_PENALTY_RST;
        foreach (tag_mem[k]) begin
            tag_mem[k] = '0;
            dirty[k] = 1'b0;
        end
        foreach (word_mem[k]) begin
            word_mem[k] = '0;
            word_ok[k] = 1'b0;
        end
        fetching = 1'b0;
        wait_cnt = '0;
        fetch_word = '0;
        fetch_addr = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: write-back, miss penalty 8, subsequent penalty 2.
        add(dmcr_pkg::CMD_TICK, '0, '0, 1'b1, '1, 1'b0);
        add(CMD_UNUSED, '1, '1, 1'b1, '0, 1'b1);
        add(dmcr_pkg::CMD_READ, ADDR_A, '0, 1'b0, '0, 1'b0);
        add(dmcr_pkg::CMD_READ, ADDR_B, '0, 1'b1, '0, 1'b0);
        add(dmcr_pkg::CMD_WRITE, ADDR_A, 32'h1357_9BDF, 1'b0, '0, 1'b0);
        add(dmcr_pkg::CMD_TICK, ADDR_A, '0, 1'b0, '1, 1'b0);
        queue_ticks(dmcr_pkg::MISS_PENALTY_RST + (BLK_WORDS - 1) * dmcr_pkg::SUB_PENALTY_RST,
                    1'b0);
        add(dmcr_pkg::CMD_READ, ADDR_A, '0, 1'b0, '0, 1'b1);
        add(dmcr_pkg::CMD_WRITE, ADDR_A, '1, 1'b0, '0, 1'b1);
        add(dmcr_pkg::CMD_READ, ADDR_A, '0, 1'b0, '0, 1'b0);
        add(dmcr_pkg::CMD_READ, ADDR_C, '0, 1'b0, '0, 1'b1);
        add(dmcr_pkg::CMD_READ, ADDR_C, '0, 1'b0, '0, 1'b0);
        settle();

        set_config(1'b1, 8'd2, 8'd1);
        add(dmcr_pkg::CMD_WRITE, 32'h0000_000C, 32'hA5A5_5A5A, 1'b0, '0, 1'b1);
        add(dmcr_pkg::CMD_WRITE, 32'h0000_000F, 32'h5A5A_A5A5, 1'b0, '0, 1'b0);
        add(dmcr_pkg::CMD_READ, 32'h0000_000C, '0, 1'b0, '0, 1'b0);
        queue_random(350);
        settle();

        long_refill_phase(1'b0, 8'd255, 8'd1);
        long_refill_phase(1'b1, 8'd0, 8'd1);

        set_config(1'b0, 8'd5, 8'd5);
        queue_random(300);
        settle();

        set_config(1'b1, 8'd3, 8'd7);
        queue_random(250);
        settle();

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/dmcr_pkg.sv
hw/rtl/direct_mapped_cache_refill_core.sv
verif/direct_mapped_cache_refill_core_tb.sv
